/* rtl/psde_pkg.sv */
// Shared constants and types of the patch distance engine.
package psde_pkg;

   localparam int MAX_DIM_DEF     = 256;
   localparam int PATCH_WIDTH_DEF = 7;

   localparam int PIX_W     = 8;
   localparam int PIXEL_W   = 3 * PIX_W;
   localparam int OTHER_W   = 10;
   localparam int COORD_W   = 12;
   localparam int DIM_REG_W = 9;
   localparam int DIST_W    = 26;
   localparam int SQ_W      = 2 * PIX_W + 2;
   localparam int CSR_IDX_W = 2;

   // The queue pointers wrap by overflow, so the depth is a power of two.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam logic [DIM_REG_W-1:0] DIM_RESET = 9'd256;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_COLS = 2'd1;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic                 is_query;
      logic                 wr_ok;
      logic [PIX_W-1:0]     a_row;
      logic [PIX_W-1:0]     a_col;
      logic [PIXEL_W-1:0]   pixel;
      logic [OTHER_W-1:0]   b_row;
      logic [OTHER_W-1:0]   b_col;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   typedef struct packed {
      logic [DIM_REG_W-1:0] rows;
      logic [DIM_REG_W-1:0] cols;
   } dims_type;

endpackage

/* rtl/psde_if.sv */
// Handshake interfaces for the request, result and register write channels.
interface psde_req_if;
   logic                               valid;
   logic                               ready;
   logic                               req_type;
   logic        [psde_pkg::PIX_W-1:0]   centre_row;
   logic        [psde_pkg::PIX_W-1:0]   centre_col;
   logic        [psde_pkg::PIX_W-1:0]   chan_l;
   logic        [psde_pkg::PIX_W-1:0]   chan_a;
   logic        [psde_pkg::PIX_W-1:0]   chan_b;
   logic signed [psde_pkg::OTHER_W-1:0] other_row;
   logic signed [psde_pkg::OTHER_W-1:0] other_col;

   modport source (output valid, req_type, centre_row, centre_col, chan_l, chan_a, chan_b,
                   other_row, other_col, input ready);
   modport sink (input valid, req_type, centre_row, centre_col, chan_l, chan_a, chan_b,
                 other_row, other_col, output ready);
endinterface

interface psde_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [psde_pkg::DIST_W-1:0]   distance;

   modport source (output valid, distance, input ready);
   modport sink (input valid, distance, output ready);
endinterface

interface psde_csr_if;
   logic                             valid;
   logic                             ready;
   logic [psde_pkg::CSR_IDX_W-1:0]   index;
   logic [psde_pkg::DIM_REG_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/psde_front.sv */
// Request front end: accepts items, classifies them and queues them for the back end.
module psde_front #(
   parameter int MAX_DIM = psde_pkg::MAX_DIM_DEF
) (
   input  logic                clock,
   input  logic                reset,
   psde_req_if.sink            req_ch,
   input  logic                pop,
   output psde_pkg::head_type  head
);

   psde_pkg::entry_type                 queue_ff [psde_pkg::QUEUE_DEPTH];
   logic [psde_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [psde_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [psde_pkg::QCNT_W-1:0]         count_ff, count_in;
   logic [psde_pkg::COORD_W-1:0]        row_ext;
   logic [psde_pkg::COORD_W-1:0]        col_ext;
   logic                                push;
   psde_pkg::entry_type                 entry_in;

   assign req_ch.ready = (count_ff != psde_pkg::QCNT_W'(psde_pkg::QUEUE_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;

   assign row_ext = psde_pkg::COORD_W'(req_ch.centre_row);
   assign col_ext = psde_pkg::COORD_W'(req_ch.centre_col);

   always_comb begin
      entry_in.is_query = (req_ch.req_type == psde_pkg::REQ_QUERY);
      entry_in.wr_ok    = (row_ext < psde_pkg::COORD_W'(MAX_DIM))
                          && (col_ext < psde_pkg::COORD_W'(MAX_DIM));
      entry_in.a_row    = req_ch.centre_row;
      entry_in.a_col    = req_ch.centre_col;
      entry_in.pixel    = {req_ch.chan_b, req_ch.chan_a, req_ch.chan_l};
      entry_in.b_row    = req_ch.other_row;
      entry_in.b_col    = req_ch.other_col;
   end

   assign wr_ptr_in = push ? psde_pkg::QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? psde_pkg::QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
   assign count_in  = psde_pkg::QCNT_W'(count_ff + psde_pkg::QCNT_W'(push)
                                        - psde_pkg::QCNT_W'(pop));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry_in;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = queue_ff[rd_ptr_ff];

endmodule

/* rtl/psde_back.sv */
// Back end: pixel store, patch scan sequencer, squared difference pipeline and result register.
module psde_back #(
   parameter int MAX_DIM     = psde_pkg::MAX_DIM_DEF,
   parameter int PATCH_WIDTH = psde_pkg::PATCH_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  psde_pkg::head_type  head,
   output logic                pop,
   input  psde_pkg::dims_type  dims,
   psde_rsp_if.source          rsp_ch
);

   localparam int DIM_W  = $clog2(MAX_DIM);
   localparam int ADDR_W = 2 * DIM_W;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int HALF   = PATCH_WIDTH / 2;
   localparam int WIN    = 2 * HALF + 1;
   localparam int IDX_W  = $clog2(WIN + 1);
   localparam int CW     = psde_pkg::COORD_W;
   localparam int PW     = psde_pkg::PIX_W;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type                          state_ff, state_in;
   logic [psde_pkg::PIXEL_W-1:0]       store [DEPTH];
   logic [PW-1:0]                      q_ar_ff, q_ac_ff;
   logic signed [psde_pkg::OTHER_W-1:0] q_br_ff, q_bc_ff;
   logic [IDX_W-1:0]                   dr_ff, dr_in, dc_ff, dc_in;
   logic                               s1_act_ff, s1_ok_ff, s2_act_ff;
   logic [psde_pkg::PIXEL_W-1:0]       rd_a_ff, rd_b_ff;
   logic [psde_pkg::SQ_W-1:0]          sq_ff, sq_sum;
   logic [psde_pkg::DIST_W-1:0]        acc_ff, acc_in;
   logic [psde_pkg::DIST_W:0]          acc_sum;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [psde_pkg::DIST_W-1:0]        rsp_dist_ff;
   logic                               start, mem_we, load_rsp, issue, last, pair_ok;
   logic signed [CW-1:0]               off_r, off_c, r1, c1, r2, c2, rows_s, cols_s;
   logic [CW-1:0]                      wr_row, wr_col;
   logic [ADDR_W-1:0]                  addr_a, addr_b, wr_addr;

   function automatic logic cell_in(input logic signed [CW-1:0] r, input logic signed [CW-1:0] c,
                                    input logic signed [CW-1:0] rows,
                                    input logic signed [CW-1:0] cols);
      return (r >= 0) && (r < rows) && (c >= 0) && (c < cols);
   endfunction

   function automatic logic [2*PW-1:0] sq_diff(input logic [PW-1:0] x, input logic [PW-1:0] y);
      logic [PW-1:0] d;
      d = (x > y) ? PW'(x - y) : PW'(y - x);
      return (2*PW)'(d * d);
   endfunction

   assign off_r  = $signed(CW'(dr_ff)) - $signed(CW'(HALF));
   assign off_c  = $signed(CW'(dc_ff)) - $signed(CW'(HALF));
   assign r1     = $signed(CW'(q_ar_ff)) + off_r;
   assign c1     = $signed(CW'(q_ac_ff)) + off_c;
   assign r2     = CW'(q_br_ff) + off_r;
   assign c2     = CW'(q_bc_ff) + off_c;
   assign rows_s = $signed(CW'(dims.rows));
   assign cols_s = $signed(CW'(dims.cols));

   assign pair_ok = cell_in(r1, c1, rows_s, cols_s) && cell_in(r2, c2, rows_s, cols_s);
   assign addr_a  = {r1[DIM_W-1:0], c1[DIM_W-1:0]};
   assign addr_b  = {r2[DIM_W-1:0], c2[DIM_W-1:0]};

   assign wr_row  = CW'(head.entry.a_row);
   assign wr_col  = CW'(head.entry.a_col);
   assign wr_addr = {wr_row[DIM_W-1:0], wr_col[DIM_W-1:0]};

   assign issue = (state_ff == ST_SCAN);
   assign last  = (dr_ff == IDX_W'(WIN - 1)) && (dc_ff == IDX_W'(WIN - 1));

   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      mem_we   = 1'b0;
      start    = 1'b0;
      load_rsp = 1'b0;
      dr_in    = dr_ff;
      dc_in    = dc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               if (head.entry.is_query) begin
                  start    = 1'b1;
                  dr_in    = '0;
                  dc_in    = '0;
                  state_in = ST_SCAN;
               end else begin
                  mem_we = head.entry.wr_ok;
               end
            end
         end
         ST_SCAN: begin
            if (last) begin
               state_in = ST_DRAIN;
            end else if (dc_ff == IDX_W'(WIN - 1)) begin
               dc_in = '0;
               dr_in = IDX_W'(dr_ff + 1'b1);
            end else begin
               dc_in = IDX_W'(dc_ff + 1'b1);
            end
         end
         ST_DRAIN: begin
            if (!s1_act_ff && !s2_act_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[wr_addr] <= head.entry.pixel;
      end
      if (issue) begin
         rd_a_ff <= store[addr_a];
         rd_b_ff <= store[addr_b];
      end
   end

   assign sq_sum = psde_pkg::SQ_W'(sq_diff(rd_a_ff[PW-1:0], rd_b_ff[PW-1:0]))
                 + psde_pkg::SQ_W'(sq_diff(rd_a_ff[2*PW-1:PW], rd_b_ff[2*PW-1:PW]))
                 + psde_pkg::SQ_W'(sq_diff(rd_a_ff[3*PW-1:2*PW], rd_b_ff[3*PW-1:2*PW]));

   // The running sum saturates at the all-ones value of the result width.
   assign acc_sum = {1'b0, acc_ff} + (psde_pkg::DIST_W + 1)'(sq_ff);
   assign acc_in  = acc_sum[psde_pkg::DIST_W] ? '1 : acc_sum[psde_pkg::DIST_W-1:0];

   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_act_ff    <= 1'b0;
         s2_act_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_act_ff    <= issue;
         s2_act_ff    <= s1_act_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dr_ff <= dr_in;
      dc_ff <= dc_in;
      if (start) begin
         q_ar_ff <= head.entry.a_row;
         q_ac_ff <= head.entry.a_col;
         q_br_ff <= $signed(head.entry.b_row);
         q_bc_ff <= $signed(head.entry.b_col);
      end
      s1_ok_ff <= pair_ok;
      if (s1_act_ff) begin
         sq_ff <= s1_ok_ff ? sq_sum : '0;
      end
      if (start) begin
         acc_ff <= '0;
      end else if (s2_act_ff) begin
         acc_ff <= acc_in;
      end
      if (load_rsp) begin
         rsp_dist_ff <= acc_ff;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.distance = rsp_dist_ff;

endmodule

/* rtl/patch_ssd_distance_engine.sv */
// Top level of the patch distance engine: image size registers, front end and back end.
//
//   channel   direction  payload
//   req_ch    in         req_type, centre_row, centre_col, chan_l/a/b, other_row, other_col
//   rsp_ch    out        distance
//   csr_ch    in         index, data (image_rows, image_cols)
//
// In the back end a pixel write is done from the idle state; a query scans a WIN x WIN
// window, WIN = 2*(PATCH_WIDTH/2)+1, and the scan reads one pixel pair a cycle
// from the two read ports of the pixel store. Reset clears control state only; the pixel
// store holds no defined value until written. A two-item queue lets requests arrive while
// a query runs, and a result waiting on rsp_ch stalls only the end of the next query.
module patch_ssd_distance_engine #(
   parameter int MAX_DIM     = psde_pkg::MAX_DIM_DEF,
   parameter int PATCH_WIDTH = psde_pkg::PATCH_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   psde_req_if.sink    req_ch,
   psde_rsp_if.source  rsp_ch,
   psde_csr_if.sink    csr_ch
);

   logic [psde_pkg::DIM_REG_W-1:0] rows_ff, rows_in;
   logic [psde_pkg::DIM_REG_W-1:0] cols_ff, cols_in;
   logic                           csr_write;
   psde_pkg::dims_type             dims;
   psde_pkg::head_type             head;
   logic                           pop;

   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid && csr_ch.ready;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_write) begin
         case (csr_ch.index)
            psde_pkg::CSR_IMAGE_ROWS: rows_in = csr_ch.data;
            psde_pkg::CSR_IMAGE_COLS: cols_in = csr_ch.data;
            default: begin
               rows_in = rows_ff;
               cols_in = cols_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= psde_pkg::DIM_RESET;
         cols_ff <= psde_pkg::DIM_RESET;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   // Sizes beyond the store act as the store's size.
   assign dims.rows = ({2'b00, rows_ff} > 11'(MAX_DIM)) ? psde_pkg::DIM_REG_W'(MAX_DIM) : rows_ff;
   assign dims.cols = ({2'b00, cols_ff} > 11'(MAX_DIM)) ? psde_pkg::DIM_REG_W'(MAX_DIM) : cols_ff;

   psde_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .pop    (pop),
      .head   (head)
   );

   psde_back #(
      .MAX_DIM     (MAX_DIM),
      .PATCH_WIDTH (PATCH_WIDTH)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .dims   (dims),
      .rsp_ch (rsp_ch)
   );

endmodule

/* tb/sv/tb_patch_ssd_distance_engine.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the patch distance engine with a built-in distance predictor.
module tb_patch_ssd_distance_engine;

   localparam int EDGE          = psde_pkg::MAX_DIM_DEF;
   localparam int HALF          = psde_pkg::PATCH_WIDTH_DEF / 2;
   localparam int SPAN          = 16;
   localparam int SETTLE_CYCLES = 64;
   localparam int RANDOM_ITEMS  = 1200;
   localparam int SIZE_PERIOD   = 100;
   localparam int QUERY_TRIES   = 16;
   localparam int FAR_OUTSIDE   = -512;
   localparam longint DIST_MAX  = (64'd1 << psde_pkg::DIST_W) - 1;

   localparam logic [psde_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [psde_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct packed {
      logic                           req_type;
      logic [psde_pkg::PIX_W-1:0]     centre_row;
      logic [psde_pkg::PIX_W-1:0]     centre_col;
      logic [psde_pkg::PIX_W-1:0]     chan_l;
      logic [psde_pkg::PIX_W-1:0]     chan_a;
      logic [psde_pkg::PIX_W-1:0]     chan_b;
      logic [psde_pkg::OTHER_W-1:0]   other_row;
      logic [psde_pkg::OTHER_W-1:0]   other_col;
   } pixel_request_type;

   typedef enum logic {STEP_SIZE, STEP_ITEM} step_kind_type;

   typedef struct packed {
      step_kind_type                  kind;
      logic [psde_pkg::DIM_REG_W-1:0] rows;
      logic [psde_pkg::DIM_REG_W-1:0] cols;
      logic                           spare;
      pixel_request_type              item;
      logic                           typed;
      logic [psde_pkg::DIST_W-1:0]    distance;
   } directed_step_type;

   logic clock = 1'b0;
   logic reset;

   psde_req_if req_ch ();
   psde_rsp_if rsp_ch ();
   psde_csr_if csr_ch ();

   logic [psde_pkg::PIXEL_W-1:0]   pixel_image [EDGE*EDGE];
   bit                             pixel_written [EDGE*EDGE];
   logic [psde_pkg::DIM_REG_W-1:0] image_rows_q;
   logic [psde_pkg::DIM_REG_W-1:0] image_cols_q;
   logic [psde_pkg::DIST_W-1:0]    distance_expected [$];
   logic [psde_pkg::DIST_W-1:0]    distance_due;
   directed_step_type              directed_steps [$];
   int                             mismatch_count = 0;
   int                             send_idle_pct = 10;
   int                             recv_idle_pct = 60;

   patch_ssd_distance_engine dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #1 clock = ~clock;

   function automatic int in_use(input logic [psde_pkg::DIM_REG_W-1:0] dim);
      return (dim > EDGE) ? EDGE : int'(dim);
   endfunction

   function automatic int reach_of(input logic [psde_pkg::DIM_REG_W-1:0] dim);
      return (in_use(dim) > SPAN) ? SPAN : in_use(dim);
   endfunction

   function automatic logic [psde_pkg::DIST_W-1:0] patch_distance(input pixel_request_type q);
      int rows, cols, ra, ca, rb, cb, dr, dc, d, k;
      longint total;
      logic [psde_pkg::PIXEL_W-1:0] pa, pb;
      rows = in_use(image_rows_q);
      cols = in_use(image_cols_q);
      total = 0;
      for (dr = -HALF; dr <= HALF; dr++) begin
         for (dc = -HALF; dc <= HALF; dc++) begin
            ra = int'(q.centre_row) + dr;
            ca = int'(q.centre_col) + dc;
            rb = int'($signed(q.other_row)) + dr;
            cb = int'($signed(q.other_col)) + dc;
            if (ra >= 0 && ra < rows && ca >= 0 && ca < cols &&
                rb >= 0 && rb < rows && cb >= 0 && cb < cols) begin
               pa = pixel_image[ra * EDGE + ca];
               pb = pixel_image[rb * EDGE + cb];
               for (k = 0; k < 3; k++) begin
                  d = int'(pa[k*psde_pkg::PIX_W +: psde_pkg::PIX_W])
                      - int'(pb[k*psde_pkg::PIX_W +: psde_pkg::PIX_W]);
                  total += d * d;
               end
            end
         end
      end
      if (total > DIST_MAX) total = DIST_MAX;
      return total[psde_pkg::DIST_W-1:0];
   endfunction

   // A query may only read pixels that were written before it.
   function automatic bit window_written(input pixel_request_type q);
      int rows, cols, ra, ca, rb, cb, dr, dc;
      rows = in_use(image_rows_q);
      cols = in_use(image_cols_q);
      for (dr = -HALF; dr <= HALF; dr++) begin
         for (dc = -HALF; dc <= HALF; dc++) begin
            ra = int'(q.centre_row) + dr;
            ca = int'(q.centre_col) + dc;
            rb = int'($signed(q.other_row)) + dr;
            cb = int'($signed(q.other_col)) + dc;
            if (ra >= 0 && ra < rows && ca >= 0 && ca < cols &&
                rb >= 0 && rb < rows && cb >= 0 && cb < cols) begin
               if (!pixel_written[ra * EDGE + ca] || !pixel_written[rb * EDGE + cb]) begin
                  return 1'b0;
               end
            end
         end
      end
      return 1'b1;
   endfunction

   function automatic logic [psde_pkg::PIX_W-1:0] random_channel();
      if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
      return psde_pkg::PIX_W'($urandom_range(255));
   endfunction

   function automatic pixel_request_type pixel_write(input int row, input int col);
      pixel_request_type r;
      r.req_type   = psde_pkg::REQ_WRITE;
      r.centre_row = row[psde_pkg::PIX_W-1:0];
      r.centre_col = col[psde_pkg::PIX_W-1:0];
      r.chan_l     = random_channel();
      r.chan_a     = random_channel();
      r.chan_b     = random_channel();
      r.other_row  = psde_pkg::OTHER_W'($urandom_range(1023));
      r.other_col  = psde_pkg::OTHER_W'($urandom_range(1023));
      return r;
   endfunction

   function automatic int write_coord();
      return ($urandom_range(7) == 0) ? $urandom_range(EDGE - 1) : $urandom_range(SPAN - 1);
   endfunction

   // Coordinates lean toward the borders of the image in use, where pairs drop out.
   function automatic int near_edge(input int limit);
      case ($urandom_range(7))
         0: return $urandom_range(HALF);
         1: return (limit > HALF) ? limit - 1 - $urandom_range(HALF) : $urandom_range(EDGE - 1);
         2: return $urandom_range(EDGE - 1);
         default: return (limit > 0) ? $urandom_range(limit - 1) : $urandom_range(EDGE - 1);
      endcase
   endfunction

   function automatic logic [psde_pkg::OTHER_W-1:0] partner_coord(input int centre,
                                                                 input int limit);
      int v;
      case ($urandom_range(9))
         0: v = $urandom_range(1023) - 512;
         1: v = -HALF - $urandom_range(1);
         2: v = limit - 1 + HALF + $urandom_range(1);
         3: v = near_edge(limit);
         default: v = centre + $urandom_range(16) - 8;
      endcase
      return v[psde_pkg::OTHER_W-1:0];
   endfunction

   function automatic pixel_request_type random_item();
      pixel_request_type r;
      int reach_r, reach_c, tries, far;
      if ($urandom_range(99) < 45) return pixel_write(write_coord(), write_coord());
      reach_r      = reach_of(image_rows_q);
      reach_c      = reach_of(image_cols_q);
      far          = FAR_OUTSIDE;
      r.req_type   = psde_pkg::REQ_QUERY;
      r.chan_l     = random_channel();
      r.chan_a     = random_channel();
      r.chan_b     = random_channel();
      for (tries = 0; tries < QUERY_TRIES; tries++) begin
         r.centre_row = psde_pkg::PIX_W'(near_edge(reach_r));
         r.centre_col = psde_pkg::PIX_W'(near_edge(reach_c));
         r.other_row  = partner_coord(int'(r.centre_row), reach_r);
         r.other_col  = partner_coord(int'(r.centre_col), reach_c);
         if (window_written(r)) return r;
      end
      r.other_row = far[psde_pkg::OTHER_W-1:0];
      r.other_col = far[psde_pkg::OTHER_W-1:0];
      return r;
   endfunction

   function automatic logic [psde_pkg::DIM_REG_W-1:0] pick_dimension();
      case ($urandom_range(11))
         0: return '0;
         1: return psde_pkg::DIM_REG_W'(1);
         2: return psde_pkg::DIM_REG_W'($urandom_range(8, 2));
         3: return psde_pkg::DIM_REG_W'(EDGE);
         4: return psde_pkg::DIM_REG_W'($urandom_range(510, EDGE + 1));
         5: return '1;
         default: return psde_pkg::DIM_REG_W'($urandom_range(SPAN + HALF, 1));
      endcase
   endfunction

   function automatic directed_step_type size_step(input int rows, input int cols,
                                                   input bit spare);
      directed_step_type s;
      s       = '0;
      s.kind  = STEP_SIZE;
      s.rows  = rows[psde_pkg::DIM_REG_W-1:0];
      s.cols  = cols[psde_pkg::DIM_REG_W-1:0];
      s.spare = spare;
      return s;
   endfunction

   function automatic directed_step_type write_step(input int row, input int col,
                                                    input logic [psde_pkg::PIXEL_W-1:0] pixel,
                                                    input int orow, input int ocol);
      directed_step_type s;
      s                 = '0;
      s.kind            = STEP_ITEM;
      s.item.req_type   = psde_pkg::REQ_WRITE;
      s.item.centre_row = row[psde_pkg::PIX_W-1:0];
      s.item.centre_col = col[psde_pkg::PIX_W-1:0];
      s.item.chan_l     = pixel[psde_pkg::PIX_W-1:0];
      s.item.chan_a     = pixel[2*psde_pkg::PIX_W-1:psde_pkg::PIX_W];
      s.item.chan_b     = pixel[3*psde_pkg::PIX_W-1:2*psde_pkg::PIX_W];
      s.item.other_row  = orow[psde_pkg::OTHER_W-1:0];
      s.item.other_col  = ocol[psde_pkg::OTHER_W-1:0];
      return s;
   endfunction

   function automatic directed_step_type query_step(input int arow, input int acol,
                                                    input int brow, input int bcol,
                                                    input bit typed, input int distance);
      directed_step_type s;
      s                 = '0;
      s.kind            = STEP_ITEM;
      s.item.req_type   = psde_pkg::REQ_QUERY;
      s.item.centre_row = arow[psde_pkg::PIX_W-1:0];
      s.item.centre_col = acol[psde_pkg::PIX_W-1:0];
      s.item.chan_l     = 8'hFF;
      s.item.chan_a     = 8'hFF;
      s.item.chan_b     = 8'hFF;
      s.item.other_row  = brow[psde_pkg::OTHER_W-1:0];
      s.item.other_col  = bcol[psde_pkg::OTHER_W-1:0];
      s.typed           = typed;
      s.distance        = distance[psde_pkg::DIST_W-1:0];
      return s;
   endfunction

   task automatic send_item(input pixel_request_type item, input bit typed,
                            input logic [psde_pkg::DIST_W-1:0] typed_distance);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= item.req_type;
      req_ch.centre_row <= item.centre_row;
      req_ch.centre_col <= item.centre_col;
      req_ch.chan_l     <= item.chan_l;
      req_ch.chan_a     <= item.chan_a;
      req_ch.chan_b     <= item.chan_b;
      req_ch.other_row  <= item.other_row;
      req_ch.other_col  <= item.other_col;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (item.req_type == psde_pkg::REQ_QUERY) begin
         distance_expected.push_back(typed ? typed_distance : patch_distance(item));
      end else begin
         pixel_image[int'(item.centre_row) * EDGE + int'(item.centre_col)] =
            {item.chan_b, item.chan_a, item.chan_l};
         pixel_written[int'(item.centre_row) * EDGE + int'(item.centre_col)] = 1'b1;
      end
   endtask

   task automatic settle_engine();
      req_ch.valid <= 1'b0;
      while (distance_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_image_size(input logic [psde_pkg::DIM_REG_W-1:0] rows,
                                 input logic [psde_pkg::DIM_REG_W-1:0] cols, input bit spare);
      int k;
      logic [psde_pkg::CSR_IDX_W-1:0] idx;
      logic [psde_pkg::DIM_REG_W-1:0] val;
      settle_engine();
      for (k = spare ? 0 : 1; k < 3; k++) begin
         case (k)
            0: begin
               idx = $urandom_range(1) ? CSR_SPARE_LO : CSR_SPARE_HI;
               val = psde_pkg::DIM_REG_W'($urandom_range(511));
            end
            1: begin
               idx = psde_pkg::CSR_IMAGE_ROWS;
               val = rows;
            end
            default: begin
               idx = psde_pkg::CSR_IMAGE_COLS;
               val = cols;
            end
         endcase
         csr_ch.valid <= 1'b1;
         csr_ch.index <= idx;
         csr_ch.data  <= val;
         @(posedge clock);
         while (!csr_ch.ready) @(posedge clock);
         case (idx)
            psde_pkg::CSR_IMAGE_ROWS: image_rows_q = val;
            psde_pkg::CSR_IMAGE_COLS: image_cols_q = val;
            default: ;
         endcase
      end
      csr_ch.valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (distance_expected.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected result: expected none, got distance %0d", rsp_ch.distance);
            end
         end else begin
            distance_due = distance_expected.pop_front();
            if (rsp_ch.distance !== distance_due) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("distance mismatch: expected %0d, got %0d", distance_due,
                           rsp_ch.distance);
               end
            end
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      int i, row, col, n;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.req_type   = psde_pkg::REQ_WRITE;
      req_ch.centre_row = '0;
      req_ch.centre_col = '0;
      req_ch.chan_l     = '0;
      req_ch.chan_a     = '0;
      req_ch.chan_b     = '0;
      req_ch.other_row  = '0;
      req_ch.other_col  = '0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = psde_pkg::CSR_IMAGE_ROWS;
      csr_ch.data       = '0;
      rsp_ch.ready      = 1'b0;
      image_rows_q      = psde_pkg::DIM_RESET;
      image_cols_q      = psde_pkg::DIM_RESET;

      // Empty windows first: no pixel is read until the corner pixels below are loaded.
      directed_steps.push_back(size_step(0, 256, 1'b1));
      directed_steps.push_back(query_step(0, 0, 0, 0, 1'b1, 0));
      directed_steps.push_back(query_step(255, 255, 511, -512, 1'b1, 0));
      directed_steps.push_back(size_step(511, 0, 1'b0));
      directed_steps.push_back(query_step(128, 128, 128, 128, 1'b1, 0));
      directed_steps.push_back(size_step(511, 256, 1'b0));
      directed_steps.push_back(query_step(128, 128, -512, -512, 1'b1, 0));
      directed_steps.push_back(query_step(0, 0, 511, 511, 1'b1, 0));
      directed_steps.push_back(query_step(3, 3, -4, -4, 1'b1, 0));
      directed_steps.push_back(write_step(0, 0, 24'hFFFFFF, -512, 511));
      directed_steps.push_back(write_step(0, 1, 24'h000000, 511, -512));
      directed_steps.push_back(write_step(1, 0, 24'h000000, 0, 0));
      directed_steps.push_back(write_step(1, 1, 24'hFFFFFF, -1, -1));
      directed_steps.push_back(size_step(2, 2, 1'b0));
      directed_steps.push_back(query_step(0, 0, 0, 1, 1'b1, 390150));
      directed_steps.push_back(query_step(1, 1, 0, 0, 1'b1, 0));
      directed_steps.push_back(query_step(0, 1, 1, 0, 1'b0, 0));
      directed_steps.push_back(query_step(0, 0, 0, 0, 1'b1, 0));
      directed_steps.push_back(size_step(1, 2, 1'b0));
      directed_steps.push_back(query_step(0, 0, 0, 1, 1'b1, 195075));
      directed_steps.push_back(size_step(1, 1, 1'b0));
      directed_steps.push_back(query_step(0, 0, 0, 1, 1'b1, 0));
      directed_steps.push_back(write_step(1, 1, 24'h4DC812, 255, -256));
      directed_steps.push_back(size_step(2, 2, 1'b0));
      directed_steps.push_back(query_step(1, 1, 1, 0, 1'b0, 0));
      directed_steps.push_back(query_step(0, 1, 1, 1, 1'b0, 0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < directed_steps.size(); i++) begin
         if (directed_steps[i].kind == STEP_SIZE) begin
            set_image_size(directed_steps[i].rows, directed_steps[i].cols,
                           directed_steps[i].spare);
         end else begin
            send_item(directed_steps[i].item, directed_steps[i].typed,
                      directed_steps[i].distance);
         end
      end

      // Load the corner region that the random queries read from.
      for (row = 0; row < SPAN; row++) begin
         for (col = 0; col < SPAN; col++) begin
            send_item(pixel_write(row, col), 1'b0, '0);
         end
      end

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            send_idle_pct = 60;
            recv_idle_pct = 10;
         end else if (n == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (n % SIZE_PERIOD == 0) begin
            if (n == 0) set_image_size(psde_pkg::DIM_RESET, psde_pkg::DIM_RESET, 1'b0);
            else set_image_size(pick_dimension(), pick_dimension(), $urandom_range(3) == 0);
         end
         send_item(random_item(), 1'b0, '0);
      end

      settle_engine();
      if (mismatch_count == 0 && distance_expected.size() == 0) begin
         $display("tb_patch_ssd_distance_engine OK");
      end else begin
         $display("tb_patch_ssd_distance_engine NOT OK");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb_patch_ssd_distance_engine NOT OK");
      $finish;
   end

endmodule
